### rtl/core/c8ie_pkg.sv
// Shared types and constants for the CHIP-8 instruction execute block.
// No dependencies; used by the channel interfaces, the execute unit and the top level.
package c8ie_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH);
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned INSTR_W     = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NUM_V       = 16;
  localparam int unsigned VIDX_W      = 4;

  localparam logic [ADDR_W-1:0]  START_RESET = 12'h200;
  localparam logic [INSTR_W-1:0] INSTR_CLS   = 16'h00E0;
  localparam logic [INSTR_W-1:0] INSTR_RET   = 16'h00EE;
  localparam logic [BYTE_W-1:0]  MISC_BCD    = 8'h33;
  localparam logic [VIDX_W-1:0]  VF_IDX      = 4'hF;

  // Top nibble of the instruction
  typedef enum logic [3:0] {
    OP_SYS     = 4'h0,
    OP_JP      = 4'h1,
    OP_CALL    = 4'h2,
    OP_SE_IMM  = 4'h3,
    OP_SNE_IMM = 4'h4,
    OP_SE_REG  = 4'h5,
    OP_LD_IMM  = 4'h6,
    OP_ADD_IMM = 4'h7,
    OP_ALU     = 4'h8,
    OP_SNE_REG = 4'h9,
    OP_LD_I    = 4'hA,
    OP_JP_V0   = 4'hB,
    OP_RND     = 4'hC,
    OP_DRW     = 4'hD,
    OP_SKP     = 4'hE,
    OP_MISC    = 4'hF
  } opcode_e;

  // Low nibble of the 8XYn group
  typedef enum logic [3:0] {
    ALU_MOV  = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_e;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic              clear_screen;
    logic              bcd_write;
    logic [ADDR_W-1:0] bcd_address;
    logic [1:0]        digit_hundreds;
    logic [3:0]        digit_tens;
    logic [3:0]        digit_ones;
    logic              unknown_opcode;
  } result_t;

  // State updates from the execute unit
  typedef struct packed {
    logic              v_we;
    logic [VIDX_W-1:0] v_waddr;
    logic [BYTE_W-1:0] v_wdata;
    logic              vf_we;
    logic              vf_wdata;
    logic              i_we;
    logic              push;
    logic              pop;
  } upd_t;

endpackage

### rtl/core/c8ie_in_if.sv
// Input channel: fetched instruction and random byte with valid/ready.
// Depends on c8ie_pkg.
interface c8ie_in_if;
  import c8ie_pkg::*;

  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instruction;
  logic [BYTE_W-1:0]  random_byte;

  modport source (output valid, output instruction, output random_byte, input ready);
  modport sink   (input valid, input instruction, input random_byte, output ready);
endinterface

### rtl/core/c8ie_out_if.sv
// Output channel: one result per executed instruction with valid/ready.
// Depends on c8ie_pkg.
interface c8ie_out_if;
  import c8ie_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] next_pc;
  logic              clear_screen;
  logic              bcd_write;
  logic [ADDR_W-1:0] bcd_address;
  logic [1:0]        digit_hundreds;
  logic [3:0]        digit_tens;
  logic [3:0]        digit_ones;
  logic              unknown_opcode;

  modport source (output valid, output next_pc, output clear_screen, output bcd_write,
                  output bcd_address, output digit_hundreds, output digit_tens,
                  output digit_ones, output unknown_opcode, input ready);
  modport sink   (input valid, input next_pc, input clear_screen, input bcd_write,
                  input bcd_address, input digit_hundreds, input digit_tens,
                  input digit_ones, input unknown_opcode, output ready);
endinterface

### rtl/core/c8ie_exec.sv
// Combinational execute unit: decode, 8-bit ALU, skip compare, BCD by constant.
// Depends on c8ie_pkg.
module c8ie_exec (
  input  logic [c8ie_pkg::INSTR_W-1:0] instruction_i,
  input  logic [c8ie_pkg::BYTE_W-1:0]  random_byte_i,
  input  logic [c8ie_pkg::ADDR_W-1:0]  pc_i,
  input  logic [c8ie_pkg::ADDR_W-1:0]  index_i,
  input  logic [c8ie_pkg::BYTE_W-1:0]  vx_i,
  input  logic [c8ie_pkg::BYTE_W-1:0]  vy_i,
  input  logic [c8ie_pkg::BYTE_W-1:0]  v0_i,
  input  logic [c8ie_pkg::ADDR_W-1:0]  stack_top_i,
  output c8ie_pkg::result_t            res_o,
  output c8ie_pkg::upd_t               upd_o
);
  import c8ie_pkg::*;

  logic [VIDX_W-1:0] x;
  logic [BYTE_W-1:0] nn;
  logic [ADDR_W-1:0] nnn;
  logic [ADDR_W-1:0] pc_plus2;
  logic [ADDR_W-1:0] pc_plus4;
  logic [BYTE_W:0]   sum;
  logic [1:0]        hund;
  logic [6:0]        rem;
  logic [14:0]       tens_prod;
  logic [3:0]        tens;
  logic [6:0]        ones;

  assign x        = instruction_i[11:8];
  assign nn       = instruction_i[7:0];
  assign nnn      = instruction_i[11:0];
  assign pc_plus2 = pc_i + ADDR_W'(2);
  assign pc_plus4 = pc_i + ADDR_W'(4);
  assign sum      = {1'b0, vx_i} + {1'b0, vy_i};

  // BCD: hundreds by compare, tens by reciprocal multiply (x*205 >> 11 is exact below 180)
  always_comb begin
    if (vx_i >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(vx_i - 8'd200);
    end else if (vx_i >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(vx_i - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = vx_i[6:0];
    end
  end

  assign tens_prod = {8'b0, rem} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones      = rem - 7'({3'b0, tens} * 7'd10);

  always_comb begin
    res_o         = '0;
    upd_o         = '0;
    res_o.next_pc = pc_plus2;
    upd_o.v_waddr = x;

    case (opcode_e'(instruction_i[15:12]))
      OP_SYS: begin
        if (instruction_i == INSTR_CLS) begin
          res_o.clear_screen = 1'b1;
        end else if (instruction_i == INSTR_RET) begin
          upd_o.pop     = 1'b1;
          res_o.next_pc = stack_top_i + ADDR_W'(2);
        end else begin
          res_o.unknown_opcode = 1'b1;
        end
      end
      OP_JP: res_o.next_pc = nnn;
      OP_CALL: begin
        upd_o.push    = 1'b1;
        res_o.next_pc = nnn;
      end
      OP_SE_IMM:  if (vx_i == nn)   res_o.next_pc = pc_plus4;
      OP_SNE_IMM: if (vx_i != nn)   res_o.next_pc = pc_plus4;
      OP_SE_REG:  if (vx_i == vy_i) res_o.next_pc = pc_plus4;
      OP_SNE_REG: if (vx_i != vy_i) res_o.next_pc = pc_plus4;
      OP_LD_IMM: begin
        upd_o.v_we    = 1'b1;
        upd_o.v_wdata = nn;
      end
      OP_ADD_IMM: begin
        upd_o.v_we    = 1'b1;
        upd_o.v_wdata = vx_i + nn;
      end
      OP_ALU: begin
        upd_o.v_we = 1'b1;
        case (alu_e'(instruction_i[3:0]))
          ALU_MOV: upd_o.v_wdata = vy_i;
          ALU_OR:  upd_o.v_wdata = vx_i | vy_i;
          ALU_AND: upd_o.v_wdata = vx_i & vy_i;
          ALU_XOR: upd_o.v_wdata = vx_i ^ vy_i;
          ALU_ADD: begin
            upd_o.v_wdata  = sum[BYTE_W-1:0];
            upd_o.vf_we    = 1'b1;
            upd_o.vf_wdata = sum[BYTE_W];
          end
          ALU_SUB: begin
            upd_o.v_wdata  = vx_i - vy_i;
            upd_o.vf_we    = 1'b1;
            upd_o.vf_wdata = (vx_i >= vy_i);
          end
          ALU_SHR: begin
            upd_o.v_wdata  = vx_i >> 1;
            upd_o.vf_we    = 1'b1;
            upd_o.vf_wdata = vx_i[0];
          end
          ALU_SUBN: begin
            upd_o.v_wdata  = vy_i - vx_i;
            upd_o.vf_we    = 1'b1;
            upd_o.vf_wdata = (vy_i >= vx_i);
          end
          ALU_SHL: begin
            upd_o.v_wdata  = vx_i << 1;
            upd_o.vf_we    = 1'b1;
            upd_o.vf_wdata = vx_i[BYTE_W-1];
          end
          default: begin
            upd_o.v_we           = 1'b0;
            res_o.unknown_opcode = 1'b1;
          end
        endcase
      end
      OP_LD_I:  upd_o.i_we = 1'b1;
      OP_JP_V0: res_o.next_pc = {4'b0, v0_i} + nnn;
      OP_RND: begin
        upd_o.v_we    = 1'b1;
        upd_o.v_wdata = random_byte_i & nn;
      end
      OP_MISC: begin
        if (nn == MISC_BCD) begin
          res_o.bcd_write      = 1'b1;
          res_o.bcd_address    = index_i;
          res_o.digit_hundreds = hund;
          res_o.digit_tens     = tens;
          res_o.digit_ones     = ones[3:0];
        end else begin
          res_o.unknown_opcode = 1'b1;
        end
      end
      default: res_o.unknown_opcode = 1'b1;
    endcase

    if (res_o.unknown_opcode) begin
      res_o.next_pc = pc_i;
    end
  end

endmodule

### rtl/core/chip8_instruction_execute_top.sv
// Latency: a result is valid the cycle after its instruction transfer.
// Throughput: one instruction per cycle; the execute unit reads PC, I, V and the
// stack top and updates them in the same cycle, so back-to-back items see fresh state.
// Input ready drops only while the output register holds a result that is not taken.
// Reset (async, active low): PC = 0x200, I = 0, V0..VF = 0, SP = 0; stack is unset.
// Top level: state registers, return stack, output register. Depends on c8ie_pkg,
// c8ie_in_if, c8ie_out_if and c8ie_exec.
module chip8_instruction_execute_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [c8ie_pkg::ADDR_W-1:0] cfg_wdata_i,
  c8ie_in_if.sink                     in_i,
  c8ie_out_if.source                  out_o
);
  import c8ie_pkg::*;

  logic [ADDR_W-1:0] pc_q;
  logic [ADDR_W-1:0] index_q;
  logic [BYTE_W-1:0] v_q [NUM_V];
  logic [SP_W-1:0]   sp_q;
  logic [ADDR_W-1:0] stack_q [STACK_DEPTH];
  logic              out_valid_q;
  result_t           res_q;

  logic [SP_W-1:0]   sp_dec;
  logic [SP_W-1:0]   sp_inc;
  logic              accept;
  result_t           res_d;
  upd_t              upd;

  assign sp_dec   = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);
  assign sp_inc   = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  c8ie_exec u_exec (
    .instruction_i (in_i.instruction),
    .random_byte_i (in_i.random_byte),
    .pc_i          (pc_q),
    .index_i       (index_q),
    .vx_i          (v_q[in_i.instruction[11:8]]),
    .vy_i          (v_q[in_i.instruction[7:4]]),
    .v0_i          (v_q[0]),
    .stack_top_i   (stack_q[sp_dec]),
    .res_o         (res_d),
    .upd_o         (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= START_RESET;
      index_q     <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_V; i++) begin
        v_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end else if (accept) begin
        pc_q <= res_d.next_pc;
      end
      if (accept) begin
        if (upd.i_we) begin
          index_q <= in_i.instruction[11:0];
        end
        if (upd.push) begin
          sp_q <= sp_inc;
        end else if (upd.pop) begin
          sp_q <= sp_dec;
        end
        // flag takes priority over the result when X is F
        for (int i = 0; i < NUM_V; i++) begin
          if (upd.vf_we && (VIDX_W'(i) == VF_IDX)) begin
            v_q[i] <= {7'b0, upd.vf_wdata};
          end else if (upd.v_we && (upd.v_waddr == VIDX_W'(i))) begin
            v_q[i] <= upd.v_wdata;
          end
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && upd.push) begin
      stack_q[sp_q] <= pc_q;
    end
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.next_pc        = res_q.next_pc;
  assign out_o.clear_screen   = res_q.clear_screen;
  assign out_o.bcd_write      = res_q.bcd_write;
  assign out_o.bcd_address    = res_q.bcd_address;
  assign out_o.digit_hundreds = res_q.digit_hundreds;
  assign out_o.digit_tens     = res_q.digit_tens;
  assign out_o.digit_ones     = res_q.digit_ones;
  assign out_o.unknown_opcode = res_q.unknown_opcode;

endmodule

### rtl/core/c8ie_checker.sv
// Port-level checks for the CHIP-8 execute top level, attached by bind.
// Depends on c8ie_pkg and chip8_instruction_execute_top.
module c8ie_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        clear_screen_i,
  input logic                        bcd_write_i,
  input logic [c8ie_pkg::ADDR_W-1:0] bcd_address_i,
  input logic [1:0]                  digit_hundreds_i,
  input logic [3:0]                  digit_tens_i,
  input logic [3:0]                  digit_ones_i,
  input logic                        unknown_opcode_i
);
  import c8ie_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output register is full");

  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("transfer in without a result next cycle");

  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_hundreds_i <= 2'd2 && digit_tens_i <= 4'd9 && digit_ones_i <= 4'd9)
    else $error("BCD digit out of range");

  a_unknown_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unknown_opcode_i |->
      !clear_screen_i && !bcd_write_i && bcd_address_i == '0)
    else $error("unknown opcode with side outputs");

endmodule

bind chip8_instruction_execute_top c8ie_checker u_c8ie_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .clear_screen_i   (out_o.clear_screen),
  .bcd_write_i      (out_o.bcd_write),
  .bcd_address_i    (out_o.bcd_address),
  .digit_hundreds_i (out_o.digit_hundreds),
  .digit_tens_i     (out_o.digit_tens),
  .digit_ones_i     (out_o.digit_ones),
  .unknown_opcode_i (out_o.unknown_opcode)
);
